// ----- rtl/core/u8sd_pkg.sv -----
// Shared types and constants of the byte-serial UTF-8 stream decoder.
`default_nettype none

package u8sd_pkg;

    // Widths of the payload fields.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned LEN_W    = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned LEFT_W   = 2;

    // Largest Unicode scalar value.
    localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BADLEAD = 2'd1,
        ST_BADCONT = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    // Sequence lengths.
    localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

    // One decoded result as held in the output stages.
    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_length;
        status_t          status;
    } result_t;

endpackage : u8sd_pkg

`default_nettype wire

// ----- rtl/core/utf8_stream_decoder.sv -----
// Top level of the byte-serial UTF-8 stream decoder.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+----------------------------------------------
//  input   | in        | in_valid / in_stall | in_byte[7:0]
//  output  | out       | out_valid/out_stall | code_point[20:0], seq_length[2:0], status[1:0]
//
// One byte is taken in every cycle while in_stall is low; the sequence state updates
// in the cycle of the transfer. The result of the byte that ends a sequence is registered.
// A skid register behind the output register keeps input flowing for one stalled result;
// the input stalls only while that skid register is full.
// Reset (rst_n, asynchronous, active low) closes any open sequence and empties both stages.
`default_nettype none

module utf8_stream_decoder
    import u8sd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [BYTE_W-1:0]   in_byte,

    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [CP_W-1:0]          code_point,
    output logic [LEN_W-1:0]         seq_length,
    output logic [STATUS_W-1:0]      status
);

    // Sequence state.
    logic [LEFT_W-1:0] bytes_left_reg, bytes_left_next;
    logic [CP_W-1:0]   acc_reg, acc_next;
    logic              cont_err_reg, cont_err_next;
    logic [LEN_W-1:0]  open_len_reg, open_len_next;

    // Output and skid stages.
    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;

    // Result produced by the current transfer.
    logic    res_valid;
    result_t res;

    logic in_xfer;
    logic out_xfer;
    logic bad_cont;
    logic [CP_W-1:0] acc_shift;

    assign in_stall = skid_valid_reg;
    assign in_xfer  = in_valid && !skid_valid_reg;
    assign out_xfer = out_valid_reg && !out_stall;

    assign bad_cont  = (in_byte[7:6] != 2'b10);
    assign acc_shift = {acc_reg[CP_W-7:0], in_byte[5:0]};

    // Decode of one byte against the open sequence.
    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        acc_next        = acc_reg;
        cont_err_next   = cont_err_reg;
        open_len_next   = open_len_reg;
        res_valid       = 1'b0;
        res.code_point  = '0;
        res.seq_length  = LEN_1;
        res.status      = ST_OK;

        if (bytes_left_reg == '0)
        begin
            priority if (!in_byte[7])
            begin
                res_valid      = 1'b1;
                res.code_point = {{(CP_W-BYTE_W){1'b0}}, in_byte};
            end
            else if (in_byte[7:6] == 2'b10)
            begin
                res_valid  = 1'b1;
                res.status = ST_BADLEAD;
            end
            else if (in_byte[7:5] == 3'b110)
            begin
                acc_next        = {{(CP_W-5){1'b0}}, in_byte[4:0]};
                bytes_left_next = LEFT_W'(1);
                open_len_next   = LEN_2;
                cont_err_next   = 1'b0;
            end
            else if (in_byte[7:4] == 4'b1110)
            begin
                acc_next        = {{(CP_W-4){1'b0}}, in_byte[3:0]};
                bytes_left_next = LEFT_W'(2);
                open_len_next   = LEN_3;
                cont_err_next   = 1'b0;
            end
            else if (in_byte[7:3] == 5'b11110)
            begin
                acc_next        = {{(CP_W-3){1'b0}}, in_byte[2:0]};
                bytes_left_next = LEFT_W'(3);
                open_len_next   = LEN_4;
                cont_err_next   = 1'b0;
            end
            else
            begin
                res_valid  = 1'b1;
                res.status = ST_BADLEAD;
            end
        end
        else
        begin
            bytes_left_next = bytes_left_reg - LEFT_W'(1);
            acc_next        = acc_shift;
            cont_err_next   = cont_err_reg | bad_cont;
            if (bytes_left_reg == LEFT_W'(1))
            begin
                // Last byte: report and close the sequence.
                res_valid      = 1'b1;
                res.seq_length = open_len_reg;
                priority if (cont_err_reg || bad_cont)
                begin
                    res.status = ST_BADCONT;
                end
                else if (acc_shift > CP_MAX)
                begin
                    res.status = ST_RANGE;
                end
                else
                begin
                    res.code_point = acc_shift;
                end
                acc_next      = '0;
                cont_err_next = 1'b0;
                open_len_next = '0;
            end
        end
    end

    // Sequence state advances on each input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            acc_reg        <= '0;
            cont_err_reg   <= 1'b0;
            open_len_reg   <= '0;
        end
        else if (in_xfer)
        begin
            bytes_left_reg <= bytes_left_next;
            acc_reg        <= acc_next;
            cont_err_reg   <= cont_err_next;
            open_len_reg   <= open_len_next;
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_xfer)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (out_valid_reg && !out_xfer)
        begin
            skid_valid_reg <= in_xfer && res_valid;
        end
        else
        begin
            out_valid_reg <= in_xfer && res_valid;
        end
    end

    // Payload of the two stages; no reset needed.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_xfer)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (out_valid_reg && !out_xfer)
        begin
            skid_data_reg <= res;
        end
        else
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_point = out_data_reg.code_point;
    assign seq_length = out_data_reg.seq_length;
    assign status     = out_data_reg.status;

    // The skid register only fills behind a held result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full with output register empty");

    // Any error result carries a zero code point.
    a_err_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status != ST_OK)
            |-> (out_data_reg.code_point == '0))
        else $error("error result with non-zero code point");

    // A range error can only close a four-byte sequence.
    a_range_len4: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status == ST_RANGE)
            |-> (out_data_reg.seq_length == LEN_4))
        else $error("range error on a sequence that is not four bytes long");

    // While a sequence is open, fewer bytes remain than its length.
    a_open_len: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_left_reg != '0) |-> ({1'b0, bytes_left_reg} < open_len_reg))
        else $error("bytes left not below the open sequence length");

endmodule : utf8_stream_decoder

`default_nettype wire
